>>> rtl/core/ats_pkg.sv
`timescale 1ns / 1ps

package ats_pkg;

    localparam int MAX_IDENT_DEF  = 63;
    localparam int VALUE_BITS_DEF = 32;
    localparam int LINE_BITS_DEF  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_REGS    = 12;

    typedef enum logic [3:0] {
        K_NEWLINE  = 4'd0,
        K_EOF      = 4'd1,
        K_COMMA    = 4'd2,
        K_PLUS     = 4'd3,
        K_MINUS    = 4'd4,
        K_STAR     = 4'd5,
        K_SLASH    = 4'd6,
        K_COLON    = 4'd7,
        K_LBRACKET = 4'd8,
        K_RBRACKET = 4'd9,
        K_REGISTER = 4'd10,
        K_IDENT    = 4'd11,
        K_NUMBER   = 4'd12,
        K_INVALID  = 4'd13,
        K_TEXT     = 4'd14
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] line_no;
        logic [31:0] number_value;
        logic [3:0]  register_index;
        logic [7:0]  text_char;
        logic [5:0]  text_length;
        logic        overlong;
        logic        last;
    } result_t;

    // Three lower-case characters, first character in the top byte.
    localparam logic [23:0] REG_NAMES [NUM_REGS] = '{
        "rax", "rbx", "rcx", "rdx", "eax", "ebx",
        "ecx", "edx", "esp", "ebp", "esi", "edi"
    };

endpackage

>>> rtl/core/ats_scan.sv
`timescale 1ns / 1ps

module ats_scan #(
    parameter int MAX_IDENT  = ats_pkg::MAX_IDENT_DEF,
    parameter int VALUE_BITS = ats_pkg::VALUE_BITS_DEF,
    parameter int LINE_BITS  = ats_pkg::LINE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        ch,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              room,
    output logic [1:0]        push_n,
    output ats_pkg::result_t  res0,
    output ats_pkg::result_t  res1
);

    localparam int LW  = (LINE_BITS > 16) ? LINE_BITS : 16;
    localparam int VW  = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam int ILW = $clog2(MAX_IDENT + 1);
    localparam int OLW = (ILW > 6) ? ILW : 6;

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_COMMENT = 6'b000010,
        M_IDENT   = 6'b000100,
        M_ZERO    = 6'b001000,
        M_DEC     = 6'b010000,
        M_HEX     = 6'b100000
    } mode_t;

    logic                  in_valid_reg;
    logic [7:0]            ch_reg;
    mode_t                 mode_reg, mode_next;
    logic [LINE_BITS-1:0]  line_count_reg, line_count_next;
    logic [LINE_BITS-1:0]  token_line_reg, token_line_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [7:0]            head_reg [3];
    logic [7:0]            head_next [3];
    logic [ILW-1:0]        ident_len_reg, ident_len_next;
    logic                  over_reg, over_next;

    logic                  step;
    logic [7:0]            c;
    logic [7:0]            lc;
    logic                  is_alpha, is_digit, is_hexl, is_hexu, is_word;
    logic [3:0]            hval;
    logic [VALUE_BITS-1:0] acc_dec, acc_hex;
    logic [LINE_BITS-1:0]  line_max;
    logic [LINE_BITS-1:0]  cfg_line;
    logic [LW-1:0]         cfg_wide;

    // Idle-path decode of the current character
    mode_t                 idle_mode;
    logic                  idle_v;
    ats_pkg::kind_t        idle_kind;
    logic                  idle_nl;
    logic                  idle_ident;
    logic                  idle_num;

    logic                  reg_hit;
    logic [3:0]            reg_idx;

    ats_pkg::result_t      pre_res, main_res;
    logic                  pre_v, main_v;

    function automatic logic [15:0] line_out(input logic [LINE_BITS-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        return w[15:0];
    endfunction

    function automatic logic [31:0] value_out(input logic [VALUE_BITS-1:0] v);
        logic [VW-1:0] w;
        w = VW'(v);
        return w[31:0];
    endfunction

    function automatic logic [5:0] len_out(input logic [ILW-1:0] v);
        logic [OLW-1:0] w;
        w = OLW'(v);
        return w[5:0];
    endfunction

    assign s_ready = !in_valid_reg || step;
    assign step    = in_valid_reg && room;
    assign c       = ch_reg;

    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_digit = (c >= "0" && c <= "9");
    assign is_hexl  = (c >= "a" && c <= "f");
    assign is_hexu  = (c >= "A" && c <= "F");
    assign is_word  = is_alpha || is_digit || (c == "_");
    assign lc       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    // Low nibble of '0'..'9' is the digit; of 'a'..'f' / 'A'..'F' it is value - 9
    assign hval     = is_digit ? c[3:0] : c[3:0] + 4'd9;
    assign acc_dec  = (acc_reg << 3) + (acc_reg << 1) + VALUE_BITS'(c[3:0]);
    assign acc_hex  = {acc_reg[VALUE_BITS-5:0], hval};

    assign line_max = '1;
    assign cfg_wide = LW'(cfg_wr_data);
    assign cfg_line = (cfg_wide > LW'(line_max)) ? line_max : cfg_wide[LINE_BITS-1:0];

    always_comb begin
        idle_mode  = M_IDLE;
        idle_v     = 1'b1;
        idle_kind  = ats_pkg::K_INVALID;
        idle_nl    = 1'b0;
        idle_ident = 1'b0;
        idle_num   = 1'b0;
        priority if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
            idle_v = 1'b0;
        end else if (c == 8'h0A) begin
            idle_kind = ats_pkg::K_NEWLINE;
            idle_nl   = 1'b1;
        end else if (c == 8'h00) begin
            idle_kind = ats_pkg::K_EOF;
        end else if (c == ",") begin
            idle_kind = ats_pkg::K_COMMA;
        end else if (c == "+") begin
            idle_kind = ats_pkg::K_PLUS;
        end else if (c == "-") begin
            idle_kind = ats_pkg::K_MINUS;
        end else if (c == "*") begin
            idle_kind = ats_pkg::K_STAR;
        end else if (c == "/") begin
            idle_kind = ats_pkg::K_SLASH;
        end else if (c == ":") begin
            idle_kind = ats_pkg::K_COLON;
        end else if (c == "[") begin
            idle_kind = ats_pkg::K_LBRACKET;
        end else if (c == "]") begin
            idle_kind = ats_pkg::K_RBRACKET;
        end else if (c == ";") begin
            idle_v    = 1'b0;
            idle_mode = M_COMMENT;
        end else if (is_alpha || c == "_") begin
            idle_kind  = ats_pkg::K_TEXT;
            idle_mode  = M_IDENT;
            idle_ident = 1'b1;
        end else if (is_digit) begin
            idle_v    = 1'b0;
            idle_num  = 1'b1;
            idle_mode = (c == "0") ? M_ZERO : M_DEC;
        end else begin
            idle_kind = ats_pkg::K_INVALID;
        end
    end

    always_comb begin
        reg_hit = 1'b0;
        reg_idx = '0;
        for (int i = 0; i < ats_pkg::NUM_REGS; i++) begin
            if (!reg_hit && {head_reg[0], head_reg[1], head_reg[2]} == ats_pkg::REG_NAMES[i]) begin
                reg_hit = 1'b1;
                reg_idx = 4'(i);
            end
        end
    end

    always_comb begin
        logic use_idle;
        use_idle        = 1'b0;
        mode_next       = mode_reg;
        line_count_next = line_count_reg;
        token_line_next = token_line_reg;
        acc_next        = acc_reg;
        head_next       = head_reg;
        ident_len_next  = ident_len_reg;
        over_next       = over_reg;
        pre_v           = 1'b0;
        main_v          = 1'b0;
        pre_res         = '0;
        main_res        = '0;

        unique case (mode_reg)
            M_IDLE: begin
                use_idle = 1'b1;
            end
            M_COMMENT: begin
                if (c == 8'h0A || c == 8'h00) begin
                    use_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_word) begin
                    if (ident_len_reg < ILW'(3)) begin
                        head_next[ident_len_reg[1:0]] = lc;
                    end
                    if (ident_len_reg < ILW'(MAX_IDENT)) begin
                        ident_len_next = ident_len_reg + ILW'(1);
                    end else begin
                        over_next = 1'b1;
                    end
                    main_v             = 1'b1;
                    main_res.kind      = ats_pkg::K_TEXT;
                    main_res.line_no   = line_out(token_line_reg);
                    main_res.text_char = lc;
                end else begin
                    pre_v               = 1'b1;
                    pre_res.line_no     = line_out(token_line_reg);
                    pre_res.text_length = len_out(ident_len_reg);
                    if (ident_len_reg == ILW'(3) && !over_reg && reg_hit) begin
                        pre_res.kind           = ats_pkg::K_REGISTER;
                        pre_res.register_index = reg_idx;
                    end else begin
                        pre_res.kind     = ats_pkg::K_IDENT;
                        pre_res.overlong = over_reg;
                    end
                    use_idle = 1'b1;
                end
            end
            M_ZERO, M_DEC, M_HEX: begin
                if (mode_reg == M_ZERO && c == "x") begin
                    mode_next = M_HEX;
                    acc_next  = '0;
                end else if (mode_reg == M_ZERO && is_digit) begin
                    mode_next = M_DEC;
                    acc_next  = VALUE_BITS'(c[3:0]);
                end else if (mode_reg == M_DEC && is_digit) begin
                    acc_next = acc_dec;
                end else if (mode_reg == M_HEX && (is_digit || is_hexl || is_hexu)) begin
                    acc_next = acc_hex;
                end else begin
                    pre_v                = 1'b1;
                    pre_res.kind         = ats_pkg::K_NUMBER;
                    pre_res.line_no      = line_out(token_line_reg);
                    pre_res.number_value = value_out(acc_reg);
                    use_idle             = 1'b1;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase

        if (use_idle) begin
            mode_next        = idle_mode;
            main_v           = idle_v;
            main_res.kind    = idle_kind;
            main_res.line_no = line_out(line_count_reg);
            if (idle_nl && line_count_reg != line_max) begin
                line_count_next = line_count_reg + LINE_BITS'(1);
            end
            if (idle_ident) begin
                token_line_next    = line_count_reg;
                head_next[0]       = lc;
                head_next[1]       = 8'h00;
                head_next[2]       = 8'h00;
                ident_len_next     = ILW'(1);
                over_next          = 1'b0;
                main_res.text_char = lc;
            end
            if (idle_num) begin
                token_line_next = line_count_reg;
                acc_next        = VALUE_BITS'(c[3:0]);
            end
        end
    end

    always_comb begin
        res0      = pre_v ? pre_res : main_res;
        res0.last = !(pre_v && main_v);
        res1      = main_res;
        res1.last = 1'b1;
        push_n    = step ? 2'({1'b0, pre_v} + {1'b0, main_v}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            mode_reg       <= M_IDLE;
            line_count_reg <= LINE_BITS'(1);
            token_line_reg <= '0;
            acc_reg        <= '0;
            head_reg       <= '{8'h00, 8'h00, 8'h00};
            ident_len_reg  <= '0;
            over_reg       <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_wr_en) begin
                line_count_reg <= cfg_line;
            end else if (step) begin
                line_count_reg <= line_count_next;
            end
            if (step) begin
                mode_reg       <= mode_next;
                token_line_reg <= token_line_next;
                acc_reg        <= acc_next;
                head_reg       <= head_next;
                ident_len_reg  <= ident_len_next;
                over_reg       <= over_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            ch_reg <= ch;
        end
    end

endmodule

>>> rtl/core/ats_outq.sv
`timescale 1ns / 1ps

module ats_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_n,
    input  ats_pkg::result_t  res0,
    input  ats_pkg::result_t  res1,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output ats_pkg::result_t  m_res
);

    localparam int PW = $clog2(ats_pkg::QUEUE_DEPTH);

    ats_pkg::result_t mem_reg [ats_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             pop;

    assign m_valid = (count_reg != '0);
    assign m_res   = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // Room for a full two-result item
    assign room    = (count_reg <= (PW+1)'(ats_pkg::QUEUE_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + (PW+1)'(push_n) - (PW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= res1;
        end
    end

endmodule

>>> rtl/core/assembly_token_scanner.sv
// An item is registered at the input; its results are then written into the result queue.
// Throughput: one item per cycle while the queue has room; two results leave as two beats.
// The four-entry result queue takes a new item only while two slots are free.
// Reset (aresetn low, synchronous) empties the pipeline, returns the scanner to idle and
// sets the line counter to 1.
`timescale 1ns / 1ps

module assembly_token_scanner #(
    parameter int MAX_IDENT  = ats_pkg::MAX_IDENT_DEF,
    parameter int VALUE_BITS = ats_pkg::VALUE_BITS_DEF,
    parameter int LINE_BITS  = ats_pkg::LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // ch
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data, // start_line
    output logic        m_tvalid,
    input  logic        m_tready,
    // line_no[15:0], number_value[47:16], register_index[51:48], text_char[59:52],
    // text_length[65:60], overlong[66], zero fill[71:67]
    output logic [71:0] m_tdata,
    output logic [3:0]  m_tuser,     // kind
    output logic        m_tlast
);

    logic             room;
    logic [1:0]       push_n;
    ats_pkg::result_t res0, res1, m_res;

    ats_scan #(
        .MAX_IDENT  (MAX_IDENT),
        .VALUE_BITS (VALUE_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .ch          (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .room        (room),
        .push_n      (push_n),
        .res0        (res0),
        .res1        (res1)
    );

    ats_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .res0    (res0),
        .res1    (res1),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    assign m_tdata = {5'b00000, m_res.overlong, m_res.text_length, m_res.text_char,
                      m_res.register_index, m_res.number_value, m_res.line_no};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule

>>> test/assembly_token_scanner_tb.sv
`timescale 1ns / 1ps

module assembly_token_scanner_tb;
    import ats_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int PHASE_ITEMS   = 219;
    localparam int NUM_PHASES    = 6;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_COMMENT,
        SCAN_IDENT,
        SCAN_ZERO,
        SCAN_DEC,
        SCAN_HEX
    } scan_mode_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic [7:0]  reps;
        logic        typed;
        kind_t       kind;
        logic [15:0] line_no;
    } stim_row_t;

    // Rows with typed set carry their own expected token (single result, all else zero).
    localparam stim_row_t DIRECTED [44] = '{
        '{8'h00, 8'd2,  1'b1, K_EOF,      16'd1},
        '{",",   8'd1,  1'b1, K_COMMA,    16'd1},
        '{"+",   8'd1,  1'b1, K_PLUS,     16'd1},
        '{"-",   8'd1,  1'b1, K_MINUS,    16'd1},
        '{"*",   8'd1,  1'b1, K_STAR,     16'd1},
        '{"/",   8'd1,  1'b1, K_SLASH,    16'd1},
        '{":",   8'd1,  1'b1, K_COLON,    16'd1},
        '{"[",   8'd1,  1'b1, K_LBRACKET, 16'd1},
        '{"]",   8'd1,  1'b1, K_RBRACKET, 16'd1},
        '{8'h80, 8'd1,  1'b1, K_INVALID,  16'd1},
        '{8'hFF, 8'd1,  1'b1, K_INVALID,  16'd1},
        '{8'h0A, 8'd1,  1'b1, K_NEWLINE,  16'd1},
        '{" ",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"E",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"a",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"X",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{8'h09, 8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"_",   8'd70, 1'b0, K_NEWLINE,  16'd0},
        '{8'h0D, 8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"0",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"x",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{",",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"0",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"X",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"1",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"]",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"0",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"5",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"a",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{" ",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"9",   8'd12, 1'b0, K_NEWLINE,  16'd0},
        '{";",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{8'hAA, 8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{8'h0A, 8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"0",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"x",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"F",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"f",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"9",   8'd9,  1'b0, K_NEWLINE,  16'd0},
        '{8'h80, 8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"z",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{8'hC8, 8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{"0",   8'd1,  1'b0, K_NEWLINE,  16'd0},
        '{8'h0A, 8'd1,  1'b0, K_NEWLINE,  16'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // scanner state mirror
    scan_mode_t  mode_q = SCAN_IDLE;
    logic [15:0] line_cnt = 16'd1;
    logic [15:0] tok_line = 16'd0;
    logic [31:0] acc = 32'd0;
    logic [7:0]  head [3] = '{8'h00, 8'h00, 8'h00};
    logic [6:0]  id_len = 7'd0;
    logic        id_over = 1'b0;

    result_t     step_toks[$];
    result_t     expected_tokens[$];
    logic [7:0]  src_text[$];

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          errors = 0;
    int          tokens_checked = 0;
    int          chars_sent = 0;
    int          cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    assembly_token_scanner u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic result_t make_tok(input kind_t k, input logic [15:0] ln);
        result_t t;
        t = '0;
        t.kind = k;
        t.line_no = ln;
        return t;
    endfunction

    function automatic string fmt_tok(input result_t t);
        return $sformatf("kind %0d line %0d value %h reg %0d char %h len %0d ovl %b last %b",
                         t.kind, t.line_no, t.number_value, t.register_index,
                         t.text_char, t.text_length, t.overlong, t.last);
    endfunction

    task automatic word_char(input logic [7:0] c);
        logic [7:0] lc;
        result_t t;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (id_len < 7'd3) head[id_len[1:0]] = lc;
        if (id_len < 7'(MAX_IDENT_DEF)) id_len = id_len + 7'd1;
        else id_over = 1'b1;
        t = make_tok(K_TEXT, tok_line);
        t.text_char = lc;
        step_toks.push_back(t);
    endtask

    task automatic close_word();
        result_t t;
        t = make_tok(K_IDENT, tok_line);
        t.text_length = id_len[5:0];
        t.overlong = id_over;
        if (id_len == 7'd3 && !id_over) begin
            for (int i = NUM_REGS - 1; i >= 0; i--) begin
                if ({head[0], head[1], head[2]} == REG_NAMES[i]) begin
                    t.kind = K_REGISTER;
                    t.register_index = 4'(i);
                end
            end
        end
        step_toks.push_back(t);
    endtask

    task automatic idle_char(input logic [7:0] c);
        result_t t;
        t = make_tok(K_INVALID, line_cnt);
        mode_q = SCAN_IDLE;
        case (c)
            " ", 8'h09, 8'h0D: return;
            8'h0A: begin
                t.kind = K_NEWLINE;
                if (line_cnt != LINE_MAX) line_cnt = line_cnt + 16'd1;
            end
            8'h00: t.kind = K_EOF;
            ",": t.kind = K_COMMA;
            "+": t.kind = K_PLUS;
            "-": t.kind = K_MINUS;
            "*": t.kind = K_STAR;
            "/": t.kind = K_SLASH;
            ":": t.kind = K_COLON;
            "[": t.kind = K_LBRACKET;
            "]": t.kind = K_RBRACKET;
            ";": begin
                mode_q = SCAN_COMMENT;
                return;
            end
            default: begin
                if (is_word_start(c)) begin
                    mode_q = SCAN_IDENT;
                    tok_line = line_cnt;
                    id_len = 7'd0;
                    id_over = 1'b0;
                    head = '{8'h00, 8'h00, 8'h00};
                    word_char(c);
                    return;
                end
                if (is_digit(c)) begin
                    tok_line = line_cnt;
                    acc = 32'(c - "0");
                    mode_q = (c == "0") ? SCAN_ZERO : SCAN_DEC;
                    return;
                end
            end
        endcase
        step_toks.push_back(t);
    endtask

    task automatic end_number(input logic [7:0] c);
        result_t t;
        t = make_tok(K_NUMBER, tok_line);
        t.number_value = acc;
        step_toks.push_back(t);
        idle_char(c);
    endtask

    // Fills step_toks with the tokens one character produces.
    task automatic scan_char(input logic [7:0] c);
        step_toks.delete();
        case (mode_q)
            SCAN_COMMENT: begin
                if (c == 8'h0A || c == 8'h00) idle_char(c);
            end
            SCAN_IDENT: begin
                if (is_word_start(c) || is_digit(c)) begin
                    word_char(c);
                end else begin
                    close_word();
                    idle_char(c);
                end
            end
            SCAN_ZERO: begin
                if (c == "x") begin
                    mode_q = SCAN_HEX;
                    acc = 32'd0;
                end else if (is_digit(c)) begin
                    mode_q = SCAN_DEC;
                    acc = 32'(c - "0");
                end else begin
                    end_number(c);
                end
            end
            SCAN_DEC: begin
                if (is_digit(c)) acc = acc * 32'd10 + 32'(c - "0");
                else end_number(c);
            end
            SCAN_HEX: begin
                if (is_digit(c)) acc = acc * 32'd16 + 32'(c - "0");
                else if (c >= "a" && c <= "f") acc = acc * 32'd16 + 32'(c - "a" + 8'd10);
                else if (c >= "A" && c <= "F") acc = acc * 32'd16 + 32'(c - "A" + 8'd10);
                else end_number(c);
            end
            default: idle_char(c);
        endcase
    endtask

    task automatic send_char(input logic [7:0] c, input bit typed, input kind_t tk,
                             input logic [15:0] tl);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scan_char(c);
        if (typed) begin
            step_toks.delete();
            step_toks.push_back(make_tok(tk, tl));
        end
        if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        while (expected_tokens.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_word_char(input bit first);
        string set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        return set[$urandom_range(0, first ? 52 : 62)];
    endfunction

    // Mostly well-formed tokens with random content, some comments and raw noise.
    task automatic gen_token();
        int pick;
        int n;
        logic [7:0] c;
        string hex_set = "0123456789abcdefABCDEF";
        string punct_set = ",+-*/:[]";
        string space_set = " \t\r";
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            for (int i = 0; i < n; i++) src_text.push_back(rand_word_char(i == 0));
        end else if (pick < 30) begin
            n = $urandom_range(0, NUM_REGS - 1);
            for (int i = 0; i < 3; i++) begin
                c = REG_NAMES[n][23 - 8 * i -: 8];
                if ($urandom_range(0, 1) == 1) c = c - 8'd32;
                src_text.push_back(c);
            end
            // near miss: one more character makes it a plain identifier
            if ($urandom_range(0, 5) == 0) src_text.push_back(rand_word_char(1'b0));
        end else if (pick < 42) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) src_text.push_back(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 52) begin
            src_text.push_back("0");
            src_text.push_back(($urandom_range(0, 7) == 0) ? "X" : "x");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) src_text.push_back(hex_set[$urandom_range(0, 21)]);
        end else if (pick < 67) begin
            src_text.push_back(punct_set[$urandom_range(0, 7)]);
        end else if (pick < 77) begin
            src_text.push_back(space_set[$urandom_range(0, 2)]);
        end else if (pick < 85) begin
            src_text.push_back(8'h0A);
        end else if (pick < 90) begin
            src_text.push_back(";");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
                do c = 8'($urandom_range(1, 255)); while (c == 8'h0A);
                src_text.push_back(c);
            end
            if ($urandom_range(0, 1) == 1) src_text.push_back(8'h0A);
        end else if (pick < 92) begin
            src_text.push_back(8'h00);
        end else begin
            src_text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin : check_tokens
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            got.line_no = m_tdata[15:0];
            got.number_value = m_tdata[47:16];
            got.register_index = m_tdata[51:48];
            got.text_char = m_tdata[59:52];
            got.text_length = m_tdata[65:60];
            got.overlong = m_tdata[66];
            got.last = m_tlast;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token: %s", $time, fmt_tok(got));
            end else begin
                want = expected_tokens.pop_front();
                tokens_checked++;
                if (got.kind !== want.kind || got.line_no !== want.line_no ||
                    got.number_value !== want.number_value ||
                    got.register_index !== want.register_index ||
                    got.text_char !== want.text_char || got.text_length !== want.text_length ||
                    got.overlong !== want.overlong || got.last !== want.last) begin
                    errors++;
                    $display("%0t: token mismatch\n  expected %s\n  actual   %s",
                             $time, fmt_tok(want), fmt_tok(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d tokens outstanding", $time, expected_tokens.size());
            $display("assembly_token_scanner: mismatch");
            $finish;
        end
    end

    initial begin
        logic [15:0] start_vals [NUM_PHASES];
        int phase_items;
        start_vals[0] = 16'd0;
        start_vals[1] = LINE_MAX;
        start_vals[2] = 16'($urandom_range(0, 65535));
        start_vals[3] = 16'd65530;
        start_vals[4] = 16'd1;
        start_vals[5] = 16'($urandom_range(0, 65535));

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 11;
        rx_idle_pct = 51;
        foreach (DIRECTED[r]) begin
            for (int k = 0; k < int'(DIRECTED[r].reps); k++) begin
                send_char(DIRECTED[r].ch, DIRECTED[r].typed, DIRECTED[r].kind,
                          DIRECTED[r].line_no);
            end
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drain();
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= start_vals[p];
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            line_cnt = start_vals[p];
            case (p / 2)
                0: begin
                    tx_idle_pct = 11;
                    rx_idle_pct = 51;
                end
                1: begin
                    tx_idle_pct = 51;
                    rx_idle_pct = 11;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            src_text.delete();
            while (phase_items < PHASE_ITEMS) begin
                if (src_text.size() == 0) gen_token();
                send_char(src_text.pop_front(), 1'b0, K_NEWLINE, 16'd0);
                phase_items++;
            end
            // leave the scanner in its idle state before the next register write
            send_char(8'h0A, 1'b0, K_NEWLINE, 16'd0);
            s_tvalid <= 1'b0;
        end

        wait_drain();
        $display("sent %0d characters, checked %0d tokens", chars_sent, tokens_checked);
        $display("start line settings: reset value plus %0d written, three idling mixes",
                 NUM_PHASES);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("assembly_token_scanner: match");
        end else begin
            $display("assembly_token_scanner: mismatch");
        end
        $finish;
    end

endmodule
